// ----- hw/rtl/snmp_pkg.sv -----
// shared types and constants for the snmp response header parser
// no dependencies; imported by every module of the block
package snmp_pkg;

   // ber tags and limits
   localparam logic [7:0] TAG_SEQ     = 8'h30;
   localparam logic [7:0] TAG_INT     = 8'h02;
   localparam logic [7:0] TAG_OCT     = 8'h04;
   localparam logic [7:0] TAG_OID     = 8'h06;
   localparam logic [7:0] TAG_NULL    = 8'h05;
   localparam logic [7:0] TAG_PDU_LO  = 8'hA0;
   localparam logic [7:0] TAG_PDU_HI  = 8'hA5;
   localparam logic [24:0] LEN_CAP    = 25'h10000;
   localparam logic [16:0] MAX_INT_BYTES = 17'd20;
   localparam logic [16:0] OFF_SAT    = 17'h1FFFF;
   localparam logic [31:0] ONES32     = 32'hFFFF_FFFF;

   // parse status codes
   localparam logic [1:0] ST_NORMAL    = 2'd0;
   localparam logic [1:0] ST_REJECTED  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // queue between parser and record output
   localparam int QUEUE_LOG   = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_LOG;

   // one varbind descriptor
   typedef struct packed {
      logic [15:0] oid_offset;
      logic [16:0] oid_len;
      logic [7:0]  value_tag;
      logic [15:0] value_offset;
      logic [16:0] value_length;
   } desc_type;

   // end-of-message summary
   typedef struct packed {
      logic [31:0] req_ident;
      logic [7:0]  pdu_type;
      logic [31:0] err_stat;
      logic [31:0] err_idx;
      logic [1:0]  parse_status;
   } sum_type;

   // records caused by one input item
   typedef struct packed {
      logic     has_desc;
      logic     has_sum;
      desc_type desc;
      sum_type  sum;
   } entry_type;

endpackage

// ----- hw/rtl/snmp_front.sv -----
// ber walk over the message, one byte per item, producing record entries
// depends on snmp_pkg
module snmp_front import snmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  pkt_byte,
   input  logic        first_byte,
   input  logic        last_byte,
   input  logic [15:0] total_length,
   output entry_type   ent
);

   localparam logic [3:0] PH_OUTER_TAG = 4'd0;
   localparam logic [3:0] PH_LEN_FIRST = 4'd1;
   localparam logic [3:0] PH_LEN_MORE  = 4'd2;
   localparam logic [3:0] PH_INT_TAG   = 4'd3;
   localparam logic [3:0] PH_INT_BODY  = 4'd4;
   localparam logic [3:0] PH_COMM_TAG  = 4'd5;
   localparam logic [3:0] PH_COMM_SKIP = 4'd6;
   localparam logic [3:0] PH_PDU_TAG   = 4'd7;
   localparam logic [3:0] PH_LIST_TAG  = 4'd8;
   localparam logic [3:0] PH_VB_TAG    = 4'd9;
   localparam logic [3:0] PH_OID_TAG   = 4'd10;
   localparam logic [3:0] PH_OID_SKIP  = 4'd11;
   localparam logic [3:0] PH_VAL_TAG   = 4'd12;
   localparam logic [3:0] PH_VAL_SKIP  = 4'd13;
   localparam logic [3:0] PH_DONE      = 4'd14;

   localparam logic [2:0] LK_OUTER = 3'd0;
   localparam logic [2:0] LK_INT   = 3'd1;
   localparam logic [2:0] LK_COMM  = 3'd2;
   localparam logic [2:0] LK_PDU   = 3'd3;
   localparam logic [2:0] LK_LIST  = 3'd4;
   localparam logic [2:0] LK_VB    = 3'd5;
   localparam logic [2:0] LK_OID   = 3'd6;
   localparam logic [2:0] LK_VAL   = 3'd7;

   typedef struct packed {
      logic [3:0]  phase;
      logic [16:0] off;
      logic [15:0] lim;
      logic [16:0] lacc;
      logic [6:0]  lleft;
      logic [63:0] iacc;
      logic [16:0] cleft;
      logic [2:0]  fsel;
      logic [31:0] rid;
      logic [31:0] est;
      logic [31:0] eidx;
      logic [7:0]  pdu;
      logic [15:0] ooff;
      logic [16:0] olen;
      logic [7:0]  vtag;
      logic [1:0]  outc;
      logic [1:0]  iwhich;
      logic [1:0]  idone;
      logic        past;
   } st_type;

   st_type st_ff, st_in, cur;
   logic [18:0] off19, nxt, lim19, endv;
   logic [24:0] lacc_new;
   logic        in_lim, ld_go, id_go, fl, fl_b, desc_go;
   logic [16:0] ld_v;

   always_comb begin
      // start from reset state on the first byte of a message
      cur = st_ff;
      if (first_byte) begin
         cur = '0;
         cur.lim = total_length;
      end
      st_in = cur;
      off19 = {2'b0, cur.off};
      nxt = off19 + 19'd1;
      lim19 = {3'b0, cur.lim};
      in_lim = off19 < lim19;
      lacc_new = {cur.lacc, pkt_byte};
      ld_go = 1'b0;
      ld_v = '0;
      id_go = 1'b0;
      fl = 1'b0;
      fl_b = 1'b0;
      desc_go = 1'b0;
      endv = '0;

      // byte handling by phase
      unique case (cur.phase)
         PH_OUTER_TAG: begin
            if (!in_lim || pkt_byte != TAG_SEQ) fl = 1'b1;
            else begin st_in.fsel = LK_OUTER; st_in.phase = PH_LEN_FIRST; end
         end
         PH_LEN_FIRST: begin
            if (!in_lim) fl = 1'b1;
            else if (pkt_byte[7]) begin
               if (pkt_byte[6:0] == 7'd0 ||
                   (off19 + {12'b0, pkt_byte[6:0]}) >= lim19) fl = 1'b1;
               else begin
                  st_in.lacc = '0;
                  st_in.lleft = pkt_byte[6:0];
                  st_in.phase = PH_LEN_MORE;
               end
            end else begin
               ld_go = 1'b1;
               ld_v = {9'b0, pkt_byte};
            end
         end
         PH_LEN_MORE: begin
            if (lacc_new > LEN_CAP) fl = 1'b1;
            else begin
               st_in.lacc = lacc_new[16:0];
               st_in.lleft = cur.lleft - 7'd1;
               if (cur.lleft == 7'd1) begin
                  ld_go = 1'b1;
                  ld_v = lacc_new[16:0];
               end
            end
         end
         PH_INT_TAG: begin
            if (!in_lim || pkt_byte != TAG_INT) fl = 1'b1;
            else begin st_in.fsel = LK_INT; st_in.phase = PH_LEN_FIRST; end
         end
         PH_INT_BODY: begin
            st_in.iacc = {cur.iacc[55:0], pkt_byte};
            st_in.cleft = cur.cleft - 17'd1;
            if (cur.cleft == 17'd1) id_go = 1'b1;
         end
         PH_COMM_TAG: begin
            if (!in_lim || pkt_byte != TAG_OCT) fl = 1'b1;
            else begin st_in.fsel = LK_COMM; st_in.phase = PH_LEN_FIRST; end
         end
         PH_COMM_SKIP, PH_OID_SKIP, PH_VAL_SKIP: begin
            st_in.cleft = cur.cleft - 17'd1;
            if (cur.cleft == 17'd1) begin
               if (cur.phase == PH_COMM_SKIP) st_in.phase = PH_PDU_TAG;
               else if (cur.phase == PH_OID_SKIP) st_in.phase = PH_VAL_TAG;
               else st_in.phase = PH_VB_TAG;
            end
         end
         PH_PDU_TAG: begin
            if (!in_lim) begin
               st_in.pdu = '0;
               fl = 1'b1;
            end else begin
               st_in.pdu = pkt_byte;
               if (pkt_byte < TAG_PDU_LO || pkt_byte > TAG_PDU_HI) fl = 1'b1;
               else begin
                  st_in.past = 1'b1;
                  st_in.fsel = LK_PDU;
                  st_in.phase = PH_LEN_FIRST;
               end
            end
         end
         PH_LIST_TAG: begin
            if (!in_lim || pkt_byte != TAG_SEQ) fl = 1'b1;
            else begin st_in.fsel = LK_LIST; st_in.phase = PH_LEN_FIRST; end
         end
         PH_VB_TAG: begin
            if (!in_lim) begin
               st_in.outc = ST_NORMAL;
               st_in.phase = PH_DONE;
            end else if (pkt_byte != TAG_SEQ) fl = 1'b1;
            else begin st_in.fsel = LK_VB; st_in.phase = PH_LEN_FIRST; end
         end
         PH_OID_TAG: begin
            if (!in_lim || pkt_byte != TAG_OID) fl = 1'b1;
            else begin st_in.fsel = LK_OID; st_in.phase = PH_LEN_FIRST; end
         end
         PH_VAL_TAG: begin
            if (!in_lim) fl = 1'b1;
            else begin
               st_in.vtag = pkt_byte;
               st_in.fsel = LK_VAL;
               st_in.phase = PH_LEN_FIRST;
            end
         end
         default: ;
      endcase

      // a complete length, handled by what it belongs to
      if (ld_go) begin
         endv = nxt + {2'b0, ld_v};
         unique case (cur.fsel)
            LK_OUTER: begin
               if (endv < lim19) st_in.lim = endv[15:0];
               st_in.iwhich = 2'd0;
               st_in.phase = PH_INT_TAG;
            end
            LK_INT: begin
               if (endv > lim19 || ld_v > MAX_INT_BYTES) fl = 1'b1;
               else begin
                  st_in.iacc = '0;
                  if (ld_v == 17'd0) id_go = 1'b1;
                  else begin st_in.cleft = ld_v; st_in.phase = PH_INT_BODY; end
               end
            end
            LK_COMM: begin
               if (ld_v == 17'd0) st_in.phase = PH_PDU_TAG;
               else begin st_in.cleft = ld_v; st_in.phase = PH_COMM_SKIP; end
            end
            LK_PDU: begin
               if (endv < lim19) st_in.lim = endv[15:0];
               st_in.iwhich = 2'd1;
               st_in.phase = PH_INT_TAG;
            end
            LK_LIST: begin
               if (endv < lim19) st_in.lim = endv[15:0];
               st_in.phase = PH_VB_TAG;
            end
            LK_VB: begin
               if (endv > lim19) fl = 1'b1;
               else st_in.phase = PH_OID_TAG;
            end
            LK_OID: begin
               if (endv > lim19) fl = 1'b1;
               else begin
                  st_in.ooff = nxt[15:0];
                  st_in.olen = ld_v;
                  if (ld_v == 17'd0) st_in.phase = PH_VAL_TAG;
                  else begin st_in.cleft = ld_v; st_in.phase = PH_OID_SKIP; end
               end
            end
            default: begin
               if (endv > lim19) fl = 1'b1;
               else begin
                  desc_go = cur.vtag != TAG_NULL;
                  if (ld_v == 17'd0) st_in.phase = PH_VB_TAG;
                  else begin st_in.cleft = ld_v; st_in.phase = PH_VAL_SKIP; end
               end
            end
         endcase
      end

      // a complete integer
      if (id_go) begin
         unique case (cur.iwhich)
            2'd0: begin
               if (st_in.iacc != 64'd0) fl = 1'b1;
               else st_in.phase = PH_COMM_TAG;
            end
            2'd1: begin
               st_in.rid = st_in.iacc[31:0];
               st_in.idone = 2'd1;
               st_in.iwhich = 2'd2;
               st_in.phase = PH_INT_TAG;
            end
            2'd2: begin
               st_in.est = st_in.iacc[31:0];
               st_in.idone = 2'd2;
               st_in.iwhich = 2'd3;
               st_in.phase = PH_INT_TAG;
            end
            default: begin
               st_in.eidx = st_in.iacc[31:0];
               st_in.idone = 2'd3;
               st_in.phase = PH_LIST_TAG;
            end
         endcase
      end

      // offset counts every byte and saturates
      if (cur.off != OFF_SAT) st_in.off = cur.off + 17'd1;

      // last byte closes an unfinished parse
      if (last_byte && !fl && st_in.phase != PH_DONE) begin
         if (st_in.phase == PH_VB_TAG && {1'b0, st_in.off} >= {2'b0, st_in.lim}) begin
            st_in.outc = ST_NORMAL;
            st_in.phase = PH_DONE;
         end else fl_b = 1'b1;
      end

      // failure: status depends on whether the pdu tag was passed
      if (fl || fl_b) begin
         if (st_in.past) begin
            st_in.outc = ST_MALFORMED;
            if (st_in.idone < 2'd1) st_in.rid = ONES32;
            if (st_in.idone < 2'd2) st_in.est = ONES32;
            if (st_in.idone < 2'd3) st_in.eidx = ONES32;
         end else st_in.outc = ST_REJECTED;
         st_in.phase = PH_DONE;
      end

      // records caused by this byte
      ent.has_desc = desc_go;
      ent.has_sum = last_byte;
      ent.desc.oid_offset = cur.ooff;
      ent.desc.oid_len = cur.olen;
      ent.desc.value_tag = cur.vtag;
      ent.desc.value_offset = nxt[15:0];
      ent.desc.value_length = ld_v;
      ent.sum.req_ident = st_in.rid;
      ent.sum.pdu_type = st_in.pdu;
      ent.sum.err_stat = st_in.est;
      ent.sum.err_idx = st_in.eidx;
      ent.sum.parse_status = st_in.outc;
   end

   // parse state register
   always_ff @(posedge clock) begin
      if (reset) st_ff <= '0;
      else if (in_valid) st_ff <= st_in;
   end

endmodule

// ----- hw/rtl/snmp_queue.sv -----
// short queue of record entries between the parser and the output side
// depends on snmp_pkg
module snmp_queue import snmp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type din,
   input  logic      pop,
   output entry_type dout,
   output logic      full,
   output logic      empty
);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_LOG-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_LOG:0]    cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full = cnt_ff == (QUEUE_LOG+1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign dout = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_LOG+1)'(do_push) - (QUEUE_LOG+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= din;
   end

endmodule

// ----- hw/rtl/snmp_back.sv -----
// output side: hands out the descriptor and the summary of each entry in turn
// depends on snmp_pkg
module snmp_back import snmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        head_empty,
   input  logic        rsp_pop,
   output logic        deq,
   output logic        rsp_record_kind,
   output logic [15:0] rsp_oid_offset,
   output logic [16:0] rsp_oid_length,
   output logic [7:0]  rsp_value_tag,
   output logic [15:0] rsp_value_offset,
   output logic [16:0] rsp_value_length,
   output logic [31:0] rsp_request_id,
   output logic [7:0]  rsp_pdu_type,
   output logic [31:0] rsp_error_status,
   output logic [31:0] rsp_error_index,
   output logic [1:0]  rsp_parse_status
);

   logic sent_ff, sent_in, show_desc, take;
   desc_type d;
   sum_type  s;

   assign show_desc = head.has_desc && !sent_ff;
   assign take = rsp_pop && !head_empty;
   assign deq = take && (!show_desc || !head.has_sum);

   // descriptor first, then the summary of the same entry
   always_comb begin
      sent_in = sent_ff;
      if (take) sent_in = show_desc && head.has_sum;
      d = show_desc ? head.desc : '0;
      s = show_desc ? '0 : head.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) sent_ff <= 1'b0;
      else sent_ff <= sent_in;
   end

   assign rsp_record_kind = !show_desc;
   assign rsp_oid_offset = d.oid_offset;
   assign rsp_oid_length = d.oid_len;
   assign rsp_value_tag = d.value_tag;
   assign rsp_value_offset = d.value_offset;
   assign rsp_value_length = d.value_length;
   assign rsp_request_id = s.req_ident;
   assign rsp_pdu_type = s.pdu_type;
   assign rsp_error_status = s.err_stat;
   assign rsp_error_index = s.err_idx;
   assign rsp_parse_status = s.parse_status;

endmodule

// ----- hw/rtl/snmp_response_header_parser.sv -----
// top level of the snmp response header parser: parser, queue, output side
// depends on snmp_pkg, snmp_front, snmp_queue, snmp_back
//
// One message byte is taken per cycle whenever full is low; the front parser
// computes the parse state combinationally from each byte and registers it, so
// bytes may arrive back to back. Each byte can cause a varbind descriptor
// and, on last_byte, a summary record; these go into a four-entry queue and
// are handed out one record per pop, so full rises only when the result side
// falls behind by four entries. A new message starts on first_byte, which
// samples total_length.
module snmp_response_header_parser import snmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_total_length,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_record_kind,
   output logic [15:0] rsp_oid_offset,
   output logic [16:0] rsp_oid_length,
   output logic [7:0]  rsp_value_tag,
   output logic [15:0] rsp_value_offset,
   output logic [16:0] rsp_value_length,
   output logic [31:0] rsp_request_id,
   output logic [7:0]  rsp_pdu_type,
   output logic [31:0] rsp_error_status,
   output logic [31:0] rsp_error_index,
   output logic [1:0]  rsp_parse_status
);

   entry_type ent, head;
   logic      acc, q_push, deq;

   assign acc = req_push && !full;
   assign q_push = acc && (ent.has_desc || ent.has_sum);

   snmp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (acc),
      .pkt_byte     (req_pkt_byte),
      .first_byte   (req_first_byte),
      .last_byte    (req_last_byte),
      .total_length (req_total_length),
      .ent          (ent)
   );

   snmp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (ent),
      .pop   (deq),
      .dout  (head),
      .full  (full),
      .empty (empty)
   );

   snmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_empty       (empty),
      .rsp_pop          (pop),
      .deq              (deq),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_oid_offset   (rsp_oid_offset),
      .rsp_oid_length   (rsp_oid_length),
      .rsp_value_tag    (rsp_value_tag),
      .rsp_value_offset (rsp_value_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_request_id   (rsp_request_id),
      .rsp_pdu_type     (rsp_pdu_type),
      .rsp_error_status (rsp_error_status),
      .rsp_error_index  (rsp_error_index),
      .rsp_parse_status (rsp_parse_status)
   );

   // an item that causes records makes a result visible next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !empty) else $error("record lost after push");

   // a descriptor taken from a two-record entry is followed by its summary
   a_desc_then_sum: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_record_kind && head.has_sum) |=> (!empty && rsp_record_kind))
      else $error("summary missing after descriptor");

   // status code three is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_parse_status != 2'd3) else $error("bad parse status");

endmodule

// ----- tb/tb_snmp_response_header_parser.sv -----
// self-checking testbench for snmp_response_header_parser
// depends on snmp_pkg and the rtl of the block; builds ber messages, predicts every record
`timescale 1ns / 100ps

module tb_snmp_response_header_parser import snmp_pkg::*; ();

   typedef logic [7:0] octets_type[$];

   // parse phases of the predictor
   typedef enum int {
      PS_OUTER_TAG, PS_LEN_FIRST, PS_LEN_MORE, PS_INT_TAG, PS_INT_BODY,
      PS_COMM_TAG, PS_COMM_SKIP, PS_PDU_TAG, PS_LIST_TAG, PS_VB_TAG,
      PS_OID_TAG, PS_OID_SKIP, PS_VAL_TAG, PS_VAL_SKIP, PS_DONE
   } parse_phase_type;

   // which length is being read
   typedef enum int {
      LK_OUTER, LK_INT, LK_COMM, LK_PDU, LK_LIST, LK_VB, LK_OID, LK_VAL
   } len_kind_type;

   // which header integer is being read
   typedef enum int {IW_VERSION, IW_REQ_ID, IW_ERR_STATUS, IW_ERR_INDEX} int_kind_type;

   localparam logic [7:0] KIND_DESC = 8'd0;
   localparam logic [7:0] KIND_SUM  = 8'd1;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         RANDOM_BYTES = 1000;

   typedef struct {
      logic        kind;
      logic [15:0] oid_offset;
      logic [16:0] oid_len;
      logic [7:0]  value_tag;
      logic [15:0] value_offset;
      logic [16:0] value_length;
      logic [31:0] req_ident;
      logic [7:0]  pdu_type;
      logic [31:0] err_stat;
      logic [31:0] err_idx;
      logic [1:0]  parse_status;
   } parse_record_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        full;
   logic [7:0]  req_pkt_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic [15:0] req_total_length;
   logic        empty;
   logic        pop;
   logic        rsp_record_kind;
   logic [15:0] rsp_oid_offset;
   logic [16:0] rsp_oid_length;
   logic [7:0]  rsp_value_tag;
   logic [15:0] rsp_value_offset;
   logic [16:0] rsp_value_length;
   logic [31:0] rsp_request_id;
   logic [7:0]  rsp_pdu_type;
   logic [31:0] rsp_error_status;
   logic [31:0] rsp_error_index;
   logic [1:0]  rsp_parse_status;

   parse_record_type expected_records[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            bytes_sent = 0;
   bit            no_idle = 0;
   int            pop_stall = 0;

   // predictor state
   parse_phase_type   ph;
   len_kind_type      len_kind;
   int_kind_type      int_which;
   int unsigned       offset, limit, len_acc, content_left;
   int unsigned       len_bytes_left;
   longint unsigned   int_acc;
   int                ints_done;
   bit                past_pdu;
   logic [31:0]       sv_request_id, sv_error_status, sv_error_index;
   logic [7:0]        sv_pdu_type, sv_value_tag;
   int unsigned       sv_oid_offset, sv_oid_length;
   logic [1:0]        outcome;

   snmp_response_header_parser u_dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------- predictor ----------------
   function automatic void clear_parse();
      ph = PS_OUTER_TAG; len_kind = LK_OUTER; int_which = IW_VERSION;
      offset = 0; limit = 0; len_acc = 0; content_left = 0; len_bytes_left = 0;
      int_acc = 0; ints_done = 0; past_pdu = 0;
      sv_request_id = 0; sv_error_status = 0; sv_error_index = 0;
      sv_pdu_type = 0; sv_value_tag = 0; sv_oid_offset = 0; sv_oid_length = 0;
      outcome = ST_NORMAL;
   endfunction

   function automatic void mark_failed();
      if (past_pdu) begin
         outcome = ST_MALFORMED;
         if (ints_done < 1) sv_request_id = ONES32;
         if (ints_done < 2) sv_error_status = ONES32;
         if (ints_done < 3) sv_error_index = ONES32;
      end else begin
         outcome = ST_REJECTED;
      end
      ph = PS_DONE;
   endfunction

   function automatic void narrow_limit(int unsigned nxt, int unsigned v);
      if (nxt + v < limit) limit = nxt + v;
   endfunction

   function automatic void start_length(len_kind_type k);
      len_kind = k;
      ph = PS_LEN_FIRST;
   endfunction

   function automatic void start_integer(int_kind_type w);
      int_which = w;
      ph = PS_INT_TAG;
   endfunction

   function automatic void integer_finished();
      unique case (int_which)
         IW_VERSION: begin
            if (int_acc != 0) mark_failed();
            else ph = PS_COMM_TAG;
         end
         IW_REQ_ID: begin
            sv_request_id = int_acc[31:0]; ints_done = 1; start_integer(IW_ERR_STATUS);
         end
         IW_ERR_STATUS: begin
            sv_error_status = int_acc[31:0]; ints_done = 2; start_integer(IW_ERR_INDEX);
         end
         default: begin
            sv_error_index = int_acc[31:0]; ints_done = 3; ph = PS_LIST_TAG;
         end
      endcase
   endfunction

   function automatic void length_finished(int unsigned v, int unsigned nxt);
      parse_record_type r;
      unique case (len_kind)
         LK_OUTER: begin narrow_limit(nxt, v); start_integer(IW_VERSION); end
         LK_INT: begin
            if (nxt + v > limit || v > MAX_INT_BYTES) begin mark_failed(); return; end
            int_acc = 0;
            if (v == 0) begin integer_finished(); return; end
            content_left = v; ph = PS_INT_BODY;
         end
         LK_COMM: begin
            if (v == 0) begin ph = PS_PDU_TAG; return; end
            content_left = v; ph = PS_COMM_SKIP;
         end
         LK_PDU: begin narrow_limit(nxt, v); start_integer(IW_REQ_ID); end
         LK_LIST: begin narrow_limit(nxt, v); ph = PS_VB_TAG; end
         LK_VB: begin
            if (nxt + v > limit) begin mark_failed(); return; end
            ph = PS_OID_TAG;
         end
         LK_OID: begin
            if (nxt + v > limit) begin mark_failed(); return; end
            sv_oid_offset = nxt; sv_oid_length = v;
            if (v == 0) begin ph = PS_VAL_TAG; return; end
            content_left = v; ph = PS_OID_SKIP;
         end
         default: begin
            if (nxt + v > limit) begin mark_failed(); return; end
            // null values give no descriptor
            if (sv_value_tag != TAG_NULL) begin
               r = '{default: '0};
               r.kind = KIND_DESC[0];
               r.oid_offset = sv_oid_offset[15:0];
               r.oid_len = sv_oid_length[16:0];
               r.value_tag = sv_value_tag;
               r.value_offset = nxt[15:0];
               r.value_length = v[16:0];
               expected_records.push_back(r);
            end
            if (v == 0) begin ph = PS_VB_TAG; return; end
            content_left = v; ph = PS_VAL_SKIP;
         end
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      int unsigned off;
      bit          in_range;
      int unsigned lol;
      off = offset;
      in_range = off < limit;
      unique case (ph)
         PS_OUTER_TAG: begin
            if (!in_range || b != TAG_SEQ) begin mark_failed(); return; end
            start_length(LK_OUTER);
         end
         PS_LEN_FIRST: begin
            if (!in_range) begin mark_failed(); return; end
            if (b[7]) begin
               lol = {25'b0, b[6:0]};
               if (lol == 0 || off + lol >= limit) begin mark_failed(); return; end
               len_acc = 0; len_bytes_left = lol; ph = PS_LEN_MORE;
            end else begin
               length_finished({24'b0, b}, off + 1);
            end
         end
         PS_LEN_MORE: begin
            len_acc = len_acc * 256 + {24'b0, b};
            if (len_acc > LEN_CAP) begin mark_failed(); return; end
            len_bytes_left--;
            if (len_bytes_left == 0) length_finished(len_acc, off + 1);
         end
         PS_INT_TAG: begin
            if (!in_range || b != TAG_INT) begin mark_failed(); return; end
            start_length(LK_INT);
         end
         PS_INT_BODY: begin
            int_acc = (int_acc << 8) | {56'b0, b};
            content_left--;
            if (content_left == 0) integer_finished();
         end
         PS_COMM_TAG: begin
            if (!in_range || b != TAG_OCT) begin mark_failed(); return; end
            start_length(LK_COMM);
         end
         PS_COMM_SKIP, PS_OID_SKIP, PS_VAL_SKIP: begin
            content_left--;
            if (content_left == 0)
               ph = (ph == PS_COMM_SKIP) ? PS_PDU_TAG :
                    (ph == PS_OID_SKIP) ? PS_VAL_TAG : PS_VB_TAG;
         end
         PS_PDU_TAG: begin
            if (!in_range) begin sv_pdu_type = 0; mark_failed(); return; end
            sv_pdu_type = b;
            if (b < TAG_PDU_LO || b > TAG_PDU_HI) begin mark_failed(); return; end
            past_pdu = 1;
            start_length(LK_PDU);
         end
         PS_LIST_TAG: begin
            if (!in_range || b != TAG_SEQ) begin mark_failed(); return; end
            start_length(LK_LIST);
         end
         PS_VB_TAG: begin
            if (!in_range) begin outcome = ST_NORMAL; ph = PS_DONE; return; end
            if (b != TAG_SEQ) begin mark_failed(); return; end
            start_length(LK_VB);
         end
         PS_OID_TAG: begin
            if (!in_range || b != TAG_OID) begin mark_failed(); return; end
            start_length(LK_OID);
         end
         PS_VAL_TAG: begin
            if (!in_range) begin mark_failed(); return; end
            sv_value_tag = b;
            start_length(LK_VAL);
         end
         default: ;
      endcase
   endfunction

   // expected records for one accepted item
   function automatic void predict_records(logic [7:0] b, logic f, logic l, logic [15:0] tl);
      parse_record_type r;
      if (f) begin
         clear_parse();
         limit = tl;
      end
      parse_byte(b);
      if (offset < OFF_SAT) offset++;
      if (l) begin
         // an early last byte ends the parse as a failed read
         if (ph != PS_DONE) begin
            if (ph == PS_VB_TAG && offset >= limit) begin
               outcome = ST_NORMAL; ph = PS_DONE;
            end else begin
               mark_failed();
            end
         end
         r = '{default: '0};
         r.kind = KIND_SUM[0];
         r.req_ident = sv_request_id;
         r.pdu_type = sv_pdu_type;
         r.err_stat = sv_error_status;
         r.err_idx = sv_error_index;
         r.parse_status = outcome;
         expected_records.push_back(r);
      end
   endfunction

   // ---------------- result side ----------------
   initial begin
      pop = 0;
      forever begin
         @(negedge clock);
         if (pop_stall > 0) begin
            pop = 0;
            pop_stall--;
         end else begin
            pop = 1;
            pop_stall = gap_cycles();
         end
      end
   end

   function automatic void check_field(string name, longint unsigned exp_v,
                                       longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // compare each popped record with the oldest expectation
   always @(posedge clock) begin
      parse_record_type e;
      if (!reset && pop && !empty) begin
         if (expected_records.size() == 0) begin
            $display("%0t unexpected record: expected none actual kind %0d",
                     $time, rsp_record_kind);
            error_count++;
         end else begin
            e = expected_records.pop_front();
            check_field("record_kind", e.kind, rsp_record_kind);
            check_field("oid_offset", e.oid_offset, rsp_oid_offset);
            check_field("oid_len", e.oid_len, rsp_oid_length);
            check_field("value_tag", e.value_tag, rsp_value_tag);
            check_field("value_offset", e.value_offset, rsp_value_offset);
            check_field("value_length", e.value_length, rsp_value_length);
            check_field("req_ident", e.req_ident, rsp_request_id);
            check_field("pdu_type", e.pdu_type, rsp_pdu_type);
            check_field("err_stat", e.err_stat, rsp_error_status);
            check_field("err_idx", e.err_idx, rsp_error_index);
            check_field("parse_status", e.parse_status, rsp_parse_status);
         end
      end
   end

   // ---------------- input side ----------------
   // called right after an accepting edge, or after push was lowered
   task automatic send_byte(logic [7:0] b, logic f, logic l, logic [15:0] tl);
      int g;
      g = gap_cycles();
      @(negedge clock);
      if (g > 0) begin
         req_push = 0;
         req_pkt_byte = 8'($urandom);
         repeat (g) @(negedge clock);
      end
      req_push = 1;
      req_pkt_byte = b;
      req_first_byte = f;
      req_last_byte = l;
      req_total_length = tl;
      do @(posedge clock); while (full);
      predict_records(b, f, l, tl);
      bytes_sent++;
   endtask

   task automatic send_message(octets_type m, logic [15:0] tl);
      foreach (m[i])
         send_byte(m[i], i == 0, i == m.size() - 1, i == 0 ? tl : 16'($urandom));
   endtask

   // hold the sender until every expected record has come
   task automatic drain();
      @(negedge clock);
      req_push = 0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------- message builder ----------------
   function automatic octets_type encode_length(int unsigned v);
      int r;
      r = $urandom_range(0, 9);
      if (v < 128 && r < 6) return '{8'(v)};
      if (v < 256 && r < 8) return '{8'h81, 8'(v)};
      if (r < 9) return '{8'h82, 8'(v >> 8), 8'(v)};
      return '{8'h83, 8'h00, 8'(v >> 8), 8'(v)};
   endfunction

   function automatic octets_type tlv(logic [7:0] tag, octets_type body);
      octets_type q;
      q = {tag, encode_length(body.size()), body};
      return q;
   endfunction

   function automatic octets_type random_octets(int lo, int hi);
      octets_type q;
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) q.push_back(8'($urandom));
      return q;
   endfunction

   function automatic octets_type integer_body();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return random_octets(20, 21);
      if (r == 1) return random_octets(0, 0);
      return random_octets(1, 8);
   endfunction

   function automatic logic [7:0] value_tag_pick();
      logic [7:0] tags[7] = '{TAG_INT, TAG_OCT, TAG_NULL, TAG_OID, 8'h40, 8'h41, 8'h43};
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return tags[$urandom_range(0, 6)];
   endfunction

   // random response, which may hold a bad integer; pdu_tag < 0 picks a legal one
   function automatic octets_type build_message(int pdu_tag, int n_vb);
      octets_type vbs, pdu, ver;
      logic [7:0] pt;
      for (int i = 0; i < n_vb; i++)
         vbs = {vbs, tlv(TAG_SEQ, {tlv(TAG_OID, random_octets(0, 6)),
                                   tlv(value_tag_pick(), random_octets(0, 5))})};
      pdu = {tlv(TAG_INT, integer_body()), tlv(TAG_INT, integer_body()),
             tlv(TAG_INT, integer_body()), tlv(TAG_SEQ, vbs)};
      pt = pdu_tag < 0 ? 8'($urandom_range(TAG_PDU_LO, TAG_PDU_HI)) : 8'(pdu_tag);
      ver = $urandom_range(0, 19) == 0 ? random_octets(1, 2) : random_octets(0, 0);
      if ($urandom_range(0, 3) == 0) ver.push_back(8'h00);
      return tlv(TAG_SEQ, {tlv(TAG_INT, ver), tlv(TAG_OCT, random_octets(0, 6)),
                           tlv(pt, pdu)});
   endfunction

   // ---------------- tests ----------------
   task automatic test_before_first();
      // no first byte since reset: limit is zero
      send_byte(8'($urandom), 0, 0, 16'($urandom));
      send_byte(TAG_SEQ, 0, 1, 16'($urandom));
      // a repeated last byte repeats the summary
      send_byte(8'($urandom), 0, 1, 16'($urandom));
      drain();
   endtask

   task automatic test_length_forms();
      octets_type m;
      // long length at the cap, over the cap, and a zero length-of-length
      m = '{TAG_SEQ, 8'h83, 8'h01, 8'h00, 8'h00, TAG_INT, 8'h00};
      send_message(m, 16'hFFFF);
      m = '{TAG_SEQ, 8'h83, 8'h01, 8'h00, 8'h01, TAG_INT};
      send_message(m, 16'hFFFF);
      m = '{TAG_SEQ, 8'h80, TAG_INT};
      send_message(m, 16'd3);
      m = '{TAG_SEQ, 8'hFF, 8'h00};
      send_message(m, 16'd1);
      drain();
   endtask

   task automatic test_integers();
      octets_type z;
      octets_type none;
      // version of twenty zero bytes passes, twenty-one fails, nonzero fails
      repeat (20) z.push_back(8'h00);
      send_message(tlv(TAG_SEQ, {tlv(TAG_INT, z), tlv(TAG_OCT, none)}), 16'd40);
      z.push_back(8'h00);
      send_message(tlv(TAG_SEQ, {tlv(TAG_INT, z)}), 16'd40);
      send_message(tlv(TAG_SEQ, {tlv(TAG_INT, '{8'h01})}), 16'd40);
      drain();
   endtask

   task automatic test_pdu_tags();
      octets_type m;
      for (int t = TAG_PDU_LO - 1; t <= TAG_PDU_HI + 1; t++) begin
         m = build_message(t, 2);
         send_message(m, 16'(m.size()));
      end
      drain();
   endtask

   task automatic test_endings();
      octets_type m;
      // trailing bytes after the message, total length three short of all bytes
      m = build_message(-1, 1);
      m = {m, random_octets(2, 4)};
      send_message(m, 16'(m.size() - 3));
      // early last byte and a short total length
      m = build_message(-1, 2);
      send_message(m[0:m.size() / 2], 16'(m.size()));
      m = build_message(-1, 2);
      send_message(m, 16'(m.size() - 2));
      drain();
   endtask

   task automatic test_random_messages();
      octets_type m;
      int msg_count;
      int r;
      msg_count = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         no_idle = $urandom_range(0, 4) == 0;
         m = build_message($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : -1,
                           $urandom_range(0, 4));
         r = $urandom_range(0, 9);
         // broken sequences: corrupted byte, truncation, trailing junk, random bytes
         if (r == 0) m[$urandom_range(0, m.size() - 1)] = 8'($urandom);
         else if (r == 1) m = m[0:$urandom_range(0, m.size() - 1)];
         else if (r == 2) m = {m, random_octets(1, 4)};
         else if (r == 3) m = random_octets(1, 12);
         r = $urandom_range(0, 19);
         send_message(m, r == 0 ? 16'hFFFF : r == 1 ? 16'($urandom_range(1, m.size()))
                                           : 16'(m.size()));
         msg_count++;
         if (msg_count % 12 == 0) drain();
      end
      no_idle = 0;
      drain();
   endtask

   initial begin
      reset = 1;
      req_push = 0;
      req_pkt_byte = 0;
      req_first_byte = 0;
      req_last_byte = 0;
      req_total_length = 0;
      clear_parse();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_before_first();
      test_length_forms();
      test_integers();
      test_pdu_tags();
      test_endings();
      test_random_messages();

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_records.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
